// File: rtl/spqd_pkg.sv
package spqd_pkg;

  // Field widths
  localparam int KEY_W       = 16;
  localparam int PRI_W       = 12;
  localparam int OP_W        = 2;
  localparam int ST_W        = 2;
  localparam int CNT_W       = 5;

  // Sizes
  localparam int SPQD_CAPACITY = 16;
  localparam int MAX_RESULTS   = 16;
  localparam int LIST_W        = $clog2(MAX_RESULTS + 1);

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_LIST   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  // One queue entry
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PRI_W-1:0] pri;
  } entry_t;

  // Commands broadcast to every cell
  typedef struct packed {
    logic capture;     // latch compare flags against the incoming beat
    logic insert;      // open a slot and shift the tail right
    logic view_load;   // copy entries into the list view
    logic view_shift;  // move the list view one place toward the head
  } cell_ctrl_t;

endpackage

// File: rtl/spqd_if.sv
interface spqd_in_if
  import spqd_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [KEY_W-1:0]  key;
  logic [PRI_W-1:0]  priority_req;
  logic [CNT_W-1:0]  list_count;

  modport source (output valid, output operation, output key, output priority_req,
                  output list_count, input ready);
  modport sink   (input valid, input operation, input key, input priority_req,
                  input list_count, output ready);
endinterface

interface spqd_out_if
  import spqd_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [ST_W-1:0]   status;
  logic [KEY_W-1:0]  out_key;
  logic [PRI_W-1:0]  out_priority;
  logic              last;

  modport source (output valid, output status, output out_key, output out_priority,
                  output last, input ready);
  modport sink   (input valid, input status, input out_key, input out_priority,
                  input last, output ready);
endinterface

// File: rtl/spqd_cell.sv
module spqd_cell
  import spqd_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic       occupied,
  input  entry_t     cmp,
  input  entry_t     new_entry,
  input  entry_t     left_entry,
  input  logic       left_ge,
  input  entry_t     right_entry,
  input  entry_t     right_view,
  input  logic       del_shift,
  output entry_t     entry,
  output logic       ge,
  output logic       match,
  output entry_t     view
);

  entry_t entry_r;
  entry_t view_r;
  logic   ge_r;
  logic   match_r;

  // Compare flags, taken when a beat is accepted
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      ge_r    <= occupied && (entry_r.pri >= cmp.pri);
      match_r <= occupied && (entry_r.key == cmp.key);
    end
  end

  // Entry storage: hold, take the new entry, or take a neighbor
  always_ff @(posedge clk) begin
    if (ctrl.insert && !ge_r) begin
      entry_r <= left_ge ? new_entry : left_entry;
    end else if (del_shift) begin
      entry_r <= right_entry;
    end
  end

  // List view: snapshot, then drains toward cell 0
  always_ff @(posedge clk) begin
    if (ctrl.view_load) begin
      view_r <= entry_r;
    end else if (ctrl.view_shift) begin
      view_r <= right_view;
    end
  end

  assign entry = entry_r;
  assign ge    = ge_r;
  assign match = match_r;
  assign view  = view_r;

endmodule

// File: rtl/sorted_priority_queue_delete_by_key_core.sv
// Insert, delete and an empty list: the result is registered in S_APPLY once the
// output register is free, set by the compare-then-shift pass through the chain; no
// new request is taken before then. List: one beat per cycle while the output is
// free, n beats for n = min(count, occupancy, 16) > 0. Code 3 is taken, with no result.
// Synchronous active-low reset empties the queue (occupancy zero) and clears
// control state; cell contents are not cleared and are unread until written.
module sorted_priority_queue_delete_by_key_core
  import spqd_pkg::*;
#(
  parameter int CAPACITY = SPQD_CAPACITY
) (
  input  logic  clk,
  input  logic  rst_n,
  spqd_in_if.sink    in_bus,
  spqd_out_if.source out_bus
);

  localparam int OCC_W = $clog2(CAPACITY + 1);
  localparam int CW    = (OCC_W > CNT_W) ? OCC_W : CNT_W;
  localparam logic [CAPACITY-1:0] ONE_V = CAPACITY'(1);

  typedef enum logic [1:0] {S_IDLE, S_APPLY, S_LIST} state_t;

  state_t             state_r;
  logic [OCC_W-1:0]   occ_r;
  op_t                op_r;
  entry_t             req_r;
  logic [LIST_W-1:0]  list_left_r;
  logic               out_valid_r;
  status_t            out_status_r;
  entry_t             out_entry_r;
  logic               out_last_r;

  cell_ctrl_t         ctrl;
  entry_t             cmp;
  entry_t             cell_e [CAPACITY];
  entry_t             cell_v [CAPACITY];
  logic [CAPACITY-1:0] ge_v, match_v, occupied_v, del_v;
  logic [CAPACITY-1:0] lowest, seen;
  entry_t             found_e;
  logic               found;
  logic               full;
  logic               in_fire, out_free, apply_fire, list_fire;
  logic [CW-1:0]      n_ext;
  logic [LIST_W-1:0]  list_n;

  // Handshake
  assign in_bus.ready = rst_n && (state_r == S_IDLE);
  assign in_fire      = in_bus.valid && in_bus.ready;
  assign out_free     = !out_valid_r || out_bus.ready;
  assign apply_fire   = (state_r == S_APPLY) && out_free;
  assign list_fire    = (state_r == S_LIST) && out_free;
  assign full         = (occ_r == OCC_W'(CAPACITY));

  assign cmp.key = in_bus.key;
  assign cmp.pri = in_bus.priority_req;

  // Broadcast commands
  assign ctrl.capture    = in_fire;
  assign ctrl.insert     = apply_fire && (op_r == OP_INSERT) && !full;
  assign ctrl.view_load  = in_fire;
  assign ctrl.view_shift = list_fire;

  // First match and everything behind it, from the registered match flags
  assign lowest = match_v & (~match_v + ONE_V);
  assign seen   = ~(match_v ^ (match_v - ONE_V)) | lowest;
  assign found  = |match_v;
  assign del_v  = (apply_fire && (op_r == OP_DELETE)) ? seen : '0;

  always_comb begin
    found_e = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (lowest[i]) found_e = found_e | cell_e[i];
    end
  end

  // Clip the list length
  always_comb begin
    n_ext = (CW'(in_bus.list_count) < CW'(occ_r)) ? CW'(in_bus.list_count) : CW'(occ_r);
    if (n_ext > CW'(MAX_RESULTS)) n_ext = CW'(MAX_RESULTS);
    list_n = LIST_W'(n_ext);
  end

  // Cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left_e, right_e, right_view;
    logic   left_g;

    assign occupied_v[i] = (occ_r > OCC_W'(i));

    if (i == 0) begin : g_head
      assign left_e = '0;
      assign left_g = 1'b1;
    end else begin : g_body
      assign left_e = cell_e[i-1];
      assign left_g = ge_v[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_e    = '0;
      assign right_view = '0;
    end else begin : g_inner
      assign right_e    = cell_e[i+1];
      assign right_view = cell_v[i+1];
    end

    spqd_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (occupied_v[i]),
      .cmp         (cmp),
      .new_entry   (req_r),
      .left_entry  (left_e),
      .left_ge     (left_g),
      .right_entry (right_e),
      .right_view  (right_view),
      .del_shift   (del_v[i]),
      .entry       (cell_e[i]),
      .ge          (ge_v[i]),
      .match       (match_v[i]),
      .view        (cell_v[i])
    );
  end

  // Sequencer, occupancy and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
      list_left_r <= '0;
    end else begin
      if (out_valid_r && out_bus.ready && !apply_fire && !list_fire) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            op_r        <= op_t'(in_bus.operation);
            req_r       <= cmp;
            list_left_r <= list_n;
            if (op_t'(in_bus.operation) == OP_NONE) begin
              state_r <= S_IDLE;
            end else if ((op_t'(in_bus.operation) == OP_LIST) && (list_n != '0)) begin
              state_r <= S_LIST;
            end else begin
              state_r <= S_APPLY;
            end
          end
        end

        S_APPLY: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_last_r  <= 1'b1;
            out_entry_r <= ((op_r == OP_DELETE) && found) ? found_e : '0;
            case (op_r)
              OP_INSERT: begin
                if (full) begin
                  out_status_r <= ST_FULL;
                end else begin
                  out_status_r <= ST_OK;
                  occ_r        <= occ_r + OCC_W'(1);
                end
              end
              OP_DELETE: begin
                if (found) begin
                  out_status_r <= ST_OK;
                  occ_r        <= occ_r - OCC_W'(1);
                end else begin
                  out_status_r <= ST_NOT_FOUND;
                end
              end
              default: begin
                out_status_r <= ST_EMPTY;
              end
            endcase
            state_r <= S_IDLE;
          end
        end

        S_LIST: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= ST_OK;
            out_entry_r  <= cell_v[0];
            out_last_r   <= (list_left_r == LIST_W'(1));
            list_left_r  <= list_left_r - LIST_W'(1);
            if (list_left_r == LIST_W'(1)) state_r <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.status       = out_status_r;
  assign out_bus.out_key      = out_entry_r.key;
  assign out_bus.out_priority = out_entry_r.pri;
  assign out_bus.last         = out_last_r;

  // Checks
  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.insert |=> occ_r == $past(occ_r) + OCC_W'(1))
    else $error("insert did not grow occupancy");

  a_full_report: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == ST_FULL)) |-> full)
    else $error("full reported while queue has room");

  a_list_last: assert property (@(posedge clk) disable iff (!rst_n)
    list_fire |=> out_last_r == ($past(list_left_r) == LIST_W'(1)))
    else $error("list last mark misplaced");

  a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_APPLY) |-> $onehot0(lowest))
    else $error("more than one delete target");

endmodule

// File: verif/sorted_priority_queue_delete_by_key_core_test.sv
`timescale 1ns / 100ps

module sorted_priority_queue_delete_by_key_core_test;
  import spqd_pkg::*;

  localparam int QUEUE_DEPTH    = SPQD_CAPACITY;
  localparam int STALL_LIMIT    = 3000;
  localparam int HOLDOFF_CYCLES = 150;
  localparam int SETTLE_CYCLES  = 20;

  // One result beat as the block should emit it
  typedef struct packed {
    status_t          status;
    logic [KEY_W-1:0] key;
    logic [PRI_W-1:0] pri;
    logic             last;
  } result_beat_t;

  // One directed stimulus row; typed rows carry their single expected beat
  typedef struct {
    op_t              op;
    logic [KEY_W-1:0] key;
    logic [PRI_W-1:0] pri;
    logic [CNT_W-1:0] cnt;
    bit               typed;
    status_t          want_status;
    logic [KEY_W-1:0] want_key;
    logic [PRI_W-1:0] want_pri;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  spqd_in_if  in_if ();
  spqd_out_if out_if ();

  sorted_priority_queue_delete_by_key_core #(
    .CAPACITY (QUEUE_DEPTH)
  ) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_if),
    .out_bus (out_if)
  );

  always #6 clk = ~clk;

  // Shadow copy of the sorted queue
  logic [KEY_W-1:0] shadow_keys [0:QUEUE_DEPTH-1];
  logic [PRI_W-1:0] shadow_pris [0:QUEUE_DEPTH-1];
  int               shadow_count;

  result_beat_t awaited_beats [$];
  stim_row_t    directed_rows [$];
  int           mismatches;
  int           send_idle_pct;
  int           recv_idle_pct;
  bit           holdoff_request;
  int           holdoff_left;

  task automatic push_result(input status_t st, input logic [KEY_W-1:0] k,
                             input logic [PRI_W-1:0] p, input logic lst);
    result_beat_t beat;
    beat.status = st;
    beat.key    = k;
    beat.pri    = p;
    beat.last   = lst;
    awaited_beats.push_back(beat);
  endtask

  // Apply one accepted operation to the shadow queue, queue its result beats
  task automatic predict_queue_op(input op_t op, input logic [KEY_W-1:0] k,
                                  input logic [PRI_W-1:0] p,
                                  input logic [CNT_W-1:0] cnt);
    int pos;
    int i;
    int n;
    case (op)
      OP_INSERT: begin
        if (shadow_count >= QUEUE_DEPTH) begin
          push_result(ST_FULL, '0, '0, 1'b1);
        end else begin
          // new entry lands after every entry of equal or higher priority
          pos = 0;
          while (pos < shadow_count && shadow_pris[pos] >= p) pos++;
          for (i = shadow_count; i > pos; i--) begin
            shadow_keys[i] = shadow_keys[i-1];
            shadow_pris[i] = shadow_pris[i-1];
          end
          shadow_keys[pos] = k;
          shadow_pris[pos] = p;
          shadow_count++;
          push_result(ST_OK, '0, '0, 1'b1);
        end
      end
      OP_DELETE: begin
        pos = 0;
        while (pos < shadow_count && shadow_keys[pos] != k) pos++;
        if (pos >= shadow_count) begin
          push_result(ST_NOT_FOUND, '0, '0, 1'b1);
        end else begin
          push_result(ST_OK, shadow_keys[pos], shadow_pris[pos], 1'b1);
          for (i = pos; i + 1 < shadow_count; i++) begin
            shadow_keys[i] = shadow_keys[i+1];
            shadow_pris[i] = shadow_pris[i+1];
          end
          shadow_count--;
        end
      end
      OP_LIST: begin
        n = int'(cnt);
        if (n > shadow_count) n = shadow_count;
        if (n > MAX_RESULTS) n = MAX_RESULTS;
        if (n == 0) begin
          push_result(ST_EMPTY, '0, '0, 1'b1);
        end else begin
          for (i = 0; i < n; i++)
            push_result(ST_OK, shadow_keys[i], shadow_pris[i], (i + 1 == n));
        end
      end
      default: ;
    endcase
  endtask

  task automatic add_row(input op_t op, input logic [KEY_W-1:0] k,
                         input logic [PRI_W-1:0] p, input logic [CNT_W-1:0] cnt,
                         input bit typed, input status_t st,
                         input logic [KEY_W-1:0] wk, input logic [PRI_W-1:0] wp);
    stim_row_t row;
    row.op          = op;
    row.key         = k;
    row.pri         = p;
    row.cnt         = cnt;
    row.typed       = typed;
    row.want_status = st;
    row.want_key    = wk;
    row.want_pri    = wp;
    directed_rows.push_back(row);
  endtask

  // Offer one beat, hold it until taken, then record what it should produce
  task automatic send_beat(input stim_row_t row);
    int depth_before;
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.operation    <= row.op;
    in_if.key          <= row.key;
    in_if.priority_req <= row.pri;
    in_if.list_count   <= row.cnt;
    do @(posedge clk); while (!in_if.ready);
    depth_before = awaited_beats.size();
    predict_queue_op(row.op, row.key, row.pri, row.cnt);
    if (row.typed) begin
      // the hand-written expectation replaces the shadow queue's beats
      while (awaited_beats.size() > depth_before) void'(awaited_beats.pop_back());
      push_result(row.want_status, row.want_key, row.want_pri, 1'b1);
    end
  endtask

  task automatic wait_for_drain();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (awaited_beats.size() != 0);
  endtask

  // Result side: check accepted beats, drive ready with random stalls
  initial begin
    result_beat_t want;
    result_beat_t got;
    out_if.ready <= 1'b0;
    holdoff_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        got.status = status_t'(out_if.status);
        got.key    = out_if.out_key;
        got.pri    = out_if.out_priority;
        got.last   = out_if.last;
        if (awaited_beats.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result beat status=%0d key=%h pri=%h last=%b",
                   $time, got.status, got.key, got.pri, got.last);
        end else begin
          want = awaited_beats.pop_front();
          if (got.status !== want.status || got.key !== want.key ||
              got.pri !== want.pri || got.last !== want.last) begin
            mismatches++;
            $display("%0t: result mismatch: expected status=%0d key=%h pri=%h last=%b",
                     $time, want.status, want.key, want.pri, want.last);
            $display("%0t:                  actual   status=%0d key=%h pri=%h last=%b",
                     $time, got.status, got.key, got.pri, got.last);
          end
        end
      end
      if (holdoff_request) begin
        holdoff_request = 1'b0;
        holdoff_left = HOLDOFF_CYCLES;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: too long without any beat moving on either side
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("FAIL sorted_priority_queue_delete_by_key_core");
    $finish;
  end

  // Stimulus
  initial begin
    stim_row_t row;
    int        phase;
    int        taken;
    int        r;
    int        i;
    bit        fill_bias;

    mismatches      = 0;
    shadow_count    = 0;
    holdoff_request = 1'b0;
    send_idle_pct   = 13;
    recv_idle_pct   = 48;
    rst_n              <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.operation    <= OP_NONE;
    in_if.key          <= '0;
    in_if.priority_req <= '0;
    in_if.list_count   <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // empty queue, ignored code, extremes, ties, full queue, duplicate keys
    add_row(OP_LIST,   16'h0000, 12'h000, 5'd5,  1'b1, ST_EMPTY,     '0, '0);
    add_row(OP_DELETE, 16'h0000, 12'h000, 5'd0,  1'b1, ST_NOT_FOUND, '0, '0);
    add_row(OP_NONE,   16'hFFFF, 12'hFFF, 5'd16, 1'b0, ST_OK,        '0, '0);
    add_row(OP_INSERT, 16'h0000, 12'h000, 5'd0,  1'b1, ST_OK,        '0, '0);
    add_row(OP_INSERT, 16'hFFFF, 12'hFFF, 5'd0,  1'b1, ST_OK,        '0, '0);
    add_row(OP_INSERT, 16'h1234, 12'hFFF, 5'd0,  1'b1, ST_OK,        '0, '0);
    add_row(OP_LIST,   16'h0000, 12'h000, 5'd16, 1'b0, ST_OK,        '0, '0);
    add_row(OP_LIST,   16'h0000, 12'h000, 5'd0,  1'b1, ST_EMPTY,     '0, '0);
    add_row(OP_DELETE, 16'hFFFF, 12'h000, 5'd0,  1'b1, ST_OK,        16'hFFFF, 12'hFFF);
    add_row(OP_DELETE, 16'h5555, 12'h000, 5'd0,  1'b1, ST_NOT_FOUND, '0, '0);
    for (i = 0; i < QUEUE_DEPTH - 2; i++)
      add_row(OP_INSERT, (i == 6) ? 16'h1234 : (16'hA5A0 ^ KEY_W'(i)),
              PRI_W'(12'h100 * (i % 5)), 5'd0, 1'b1, ST_OK, '0, '0);
    add_row(OP_INSERT, 16'h7777, 12'h800, 5'd0,  1'b1, ST_FULL,      '0, '0);
    add_row(OP_LIST,   16'h0000, 12'h000, 5'd16, 1'b0, ST_OK,        '0, '0);
    add_row(OP_DELETE, 16'h1234, 12'h000, 5'd0,  1'b0, ST_OK,        '0, '0);
    add_row(OP_DELETE, 16'h0000, 12'h000, 5'd0,  1'b0, ST_OK,        '0, '0);

    foreach (directed_rows[j]) send_beat(directed_rows[j]);
    wait_for_drain();

    // Random part in three idle profiles; fill and drain biases alternate
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 13; recv_idle_pct = 48; holdoff_request = 1'b1; end
        1: begin send_idle_pct = 48; recv_idle_pct = 13; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      taken = 0;
      while (taken < 114) begin
        fill_bias = ((taken / 31) % 2 == 0);
        r = $urandom_range(99);
        if (r < 2)
          row.op = OP_NONE;
        else if (r < (fill_bias ? 67 : 27))
          row.op = OP_INSERT;
        else if (r < (fill_bias ? 84 : 80))
          row.op = OP_DELETE;
        else
          row.op = OP_LIST;

        // deletes mostly aim at keys that are present
        if (row.op == OP_DELETE && shadow_count > 0 && $urandom_range(3) != 0)
          row.key = shadow_keys[$urandom_range(shadow_count - 1)];
        else if ($urandom_range(1) == 0)
          row.key = 16'h00F0 + KEY_W'($urandom_range(7));
        else
          row.key = KEY_W'($urandom_range(16'hFFFF));

        case ($urandom_range(4))
          0: row.pri = 12'h000;
          1: row.pri = 12'hFFF;
          2: row.pri = 12'h800;
          default: row.pri = PRI_W'($urandom_range(12'hFFF));
        endcase

        case ($urandom_range(9))
          0: row.cnt = 5'd0;
          1: row.cnt = 5'd16;
          default: row.cnt = CNT_W'($urandom_range(16));
        endcase

        row.typed = 1'b0;
        send_beat(row);
        if (row.op != OP_NONE) taken++;
      end
      wait_for_drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("PASS sorted_priority_queue_delete_by_key_core");
    else
      $display("FAIL sorted_priority_queue_delete_by_key_core");
    $finish;
  end

endmodule

// File: sim.f
rtl/spqd_pkg.sv
rtl/spqd_if.sv
rtl/spqd_cell.sv
rtl/sorted_priority_queue_delete_by_key_core.sv
verif/sorted_priority_queue_delete_by_key_core_test.sv
